FILE: sv/rc4_pkg.sv
package rc4_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned SBOX_DEPTH    = 256;
  localparam int unsigned SBOX_AW       = 8;
  localparam int unsigned MAX_KEY_BYTES = 256;
  localparam int unsigned KEY_AW        = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned KEY_CW        = $clog2(MAX_KEY_BYTES + 1);

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] item_byte;
    logic              key_last;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] cipher_byte;
    logic              keyed;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_KEY_WR,
    OP_FILL,
    OP_SCH_RD_N,
    OP_SCH_RD_ACC,
    OP_SCH_WR_N,
    OP_SCH_WR_ACC,
    OP_GEN_RD_I,
    OP_GEN_RD_J,
    OP_GEN_WR_I,
    OP_GEN_WR_J,
    OP_GEN_RD_T,
    OP_OUT_KEYED,
    OP_OUT_RAW
  } dp_op_e;

  typedef struct packed {
    logic   load_item;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic key_last;
    logic key_ready;
    logic n_wrap;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: sv/rc4_ram.sv
module rc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data is registered and holds until the next read, so a value can still be used after later writes.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/rc4_ctrl.sv
module rc4_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rc4_pkg::dp_sts_t sts_i,
  output rc4_pkg::dp_cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DISP = 4'd1;
  localparam logic [3:0] ST_RAW  = 4'd2;
  localparam logic [3:0] ST_FILL = 4'd3;
  localparam logic [3:0] ST_S1   = 4'd4;
  localparam logic [3:0] ST_S2   = 4'd5;
  localparam logic [3:0] ST_S3   = 4'd6;
  localparam logic [3:0] ST_S4   = 4'd7;
  localparam logic [3:0] ST_G1   = 4'd8;
  localparam logic [3:0] ST_G2   = 4'd9;
  localparam logic [3:0] ST_G3   = 4'd10;
  localparam logic [3:0] ST_G4   = 4'd11;
  localparam logic [3:0] ST_G5   = 4'd12;
  localparam logic [3:0] ST_G6   = 4'd13;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d         = state_q;
    cmd_o.load_item = 1'b0;
    cmd_o.op        = rc4_pkg::OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_DISP;
        end
      end
      ST_DISP: begin
        if (!sts_i.mode) begin
          cmd_o.op = rc4_pkg::OP_KEY_WR;
          state_d  = sts_i.key_last ? ST_FILL : ST_IDLE;
        end else begin
          state_d = sts_i.key_ready ? ST_G1 : ST_RAW;
        end
      end
      ST_RAW: begin
        if (sts_i.out_free) begin
          cmd_o.op = rc4_pkg::OP_OUT_RAW;
          state_d  = ST_IDLE;
        end
      end
      ST_FILL: begin
        cmd_o.op = rc4_pkg::OP_FILL;
        if (sts_i.n_wrap) begin
          state_d = ST_S1;
        end
      end
      ST_S1: begin
        cmd_o.op = rc4_pkg::OP_SCH_RD_N;
        state_d  = ST_S2;
      end
      ST_S2: begin
        cmd_o.op = rc4_pkg::OP_SCH_RD_ACC;
        state_d  = ST_S3;
      end
      ST_S3: begin
        cmd_o.op = rc4_pkg::OP_SCH_WR_N;
        state_d  = ST_S4;
      end
      ST_S4: begin
        cmd_o.op = rc4_pkg::OP_SCH_WR_ACC;
        state_d  = sts_i.n_wrap ? ST_IDLE : ST_S1;
      end
      ST_G1: begin
        cmd_o.op = rc4_pkg::OP_GEN_RD_I;
        state_d  = ST_G2;
      end
      ST_G2: begin
        cmd_o.op = rc4_pkg::OP_GEN_RD_J;
        state_d  = ST_G3;
      end
      ST_G3: begin
        cmd_o.op = rc4_pkg::OP_GEN_WR_I;
        state_d  = ST_G4;
      end
      ST_G4: begin
        cmd_o.op = rc4_pkg::OP_GEN_WR_J;
        state_d  = ST_G5;
      end
      ST_G5: begin
        cmd_o.op = rc4_pkg::OP_GEN_RD_T;
        state_d  = ST_G6;
      end
      ST_G6: begin
        if (sts_i.out_free) begin
          cmd_o.op = rc4_pkg::OP_OUT_KEYED;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A result is only written into the output register when that register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == rc4_pkg::OP_OUT_KEYED || cmd_o.op == rc4_pkg::OP_OUT_RAW) |-> sts_i.out_free)
    else $error("output register loaded while occupied");

  // Dispatch is always entered straight from idle with a freshly captured item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DISP) |-> ($past(state_q) == ST_IDLE && $past(cmd_o.load_item)))
    else $error("dispatch without a captured item");

  // The last schedule step returns the controller to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_S4 && sts_i.n_wrap) |=> (state_q == ST_IDLE))
    else $error("key schedule did not finish after the last step");

endmodule

FILE: sv/rc4_dp.sv
module rc4_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rc4_pkg::in_t     in_item_i,
  input  rc4_pkg::dp_cmd_t cmd_i,
  output rc4_pkg::dp_sts_t sts_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rc4_pkg::out_t    out_item_o
);

  localparam int unsigned BW  = rc4_pkg::BYTE_W;
  localparam int unsigned SAW = rc4_pkg::SBOX_AW;
  localparam int unsigned KAW = rc4_pkg::KEY_AW;
  localparam int unsigned KCW = rc4_pkg::KEY_CW;

  rc4_pkg::in_t  item_q;
  rc4_pkg::out_t out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic [KCW-1:0] key_count_q, key_count_d;
  logic           key_open_q, key_open_d;
  logic           key_ready_q, key_ready_d;

  logic [SAW-1:0] n_q, n_d;
  logic [KAW-1:0] k_q, k_d;
  logic [BW-1:0]  acc_q, acc_d;
  logic [BW-1:0]  i_q, i_d;
  logic [BW-1:0]  j_q, j_d;
  logic [BW-1:0]  hold_a_q, hold_a_d;
  logic [BW-1:0]  hold_b_q, hold_b_d;

  logic           s_en, s_we;
  logic [SAW-1:0] s_addr;
  logic [BW-1:0]  s_wdata, s_rdata;
  logic           k_en, k_we;
  logic [KAW-1:0] k_addr;
  logic [BW-1:0]  k_wdata, k_rdata;

  logic [KCW-1:0] cnt_base;
  logic           out_free;

  assign cnt_base = key_open_q ? key_count_q : '0;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    key_count_d = key_count_q;
    key_open_d  = key_open_q;
    key_ready_d = key_ready_q;
    n_d         = n_q;
    k_d         = k_q;
    acc_d       = acc_q;
    i_d         = i_q;
    j_d         = j_q;
    hold_a_d    = hold_a_q;
    hold_b_d    = hold_b_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    s_en        = 1'b0;
    s_we        = 1'b0;
    s_addr      = n_q;
    s_wdata     = s_rdata;
    k_en        = 1'b0;
    k_we        = 1'b0;
    k_addr      = k_q;
    k_wdata     = item_q.item_byte;
    unique case (cmd_i.op)
      rc4_pkg::OP_NONE: begin
      end
      rc4_pkg::OP_KEY_WR: begin
        // A key byte while no key is open starts a new key; extra bytes are dropped.
        key_open_d  = !item_q.key_last;
        key_ready_d = item_q.key_last;
        key_count_d = cnt_base;
        if (cnt_base < KCW'(rc4_pkg::MAX_KEY_BYTES)) begin
          k_en        = 1'b1;
          k_we        = 1'b1;
          k_addr      = cnt_base[KAW-1:0];
          key_count_d = cnt_base + KCW'(1);
        end
        n_d   = '0;
        k_d   = '0;
        acc_d = '0;
      end
      rc4_pkg::OP_FILL: begin
        s_en    = 1'b1;
        s_we    = 1'b1;
        s_addr  = n_q;
        s_wdata = BW'(n_q);
        n_d     = n_q + SAW'(1);
      end
      rc4_pkg::OP_SCH_RD_N: begin
        s_en   = 1'b1;
        s_addr = n_q;
        k_en   = 1'b1;
        k_addr = k_q;
      end
      rc4_pkg::OP_SCH_RD_ACC: begin
        acc_d    = acc_q + s_rdata + k_rdata;
        hold_a_d = s_rdata;
        s_en     = 1'b1;
        s_addr   = SAW'(acc_d);
      end
      rc4_pkg::OP_SCH_WR_N: begin
        s_en    = 1'b1;
        s_we    = 1'b1;
        s_addr  = n_q;
        s_wdata = s_rdata;
      end
      rc4_pkg::OP_SCH_WR_ACC: begin
        s_en    = 1'b1;
        s_we    = 1'b1;
        s_addr  = SAW'(acc_q);
        s_wdata = hold_a_q;
        n_d     = n_q + SAW'(1);
        // The key index runs modulo the key length.
        if ((KCW'(k_q) + KCW'(1)) == key_count_q) begin
          k_d = '0;
        end else begin
          k_d = k_q + KAW'(1);
        end
        if (n_q == SAW'(rc4_pkg::SBOX_DEPTH - 1)) begin
          i_d = '0;
          j_d = '0;
        end
      end
      rc4_pkg::OP_GEN_RD_I: begin
        i_d    = i_q + BW'(1);
        s_en   = 1'b1;
        s_addr = SAW'(i_d);
      end
      rc4_pkg::OP_GEN_RD_J: begin
        j_d      = j_q + s_rdata;
        hold_a_d = s_rdata;
        s_en     = 1'b1;
        s_addr   = SAW'(j_d);
      end
      rc4_pkg::OP_GEN_WR_I: begin
        hold_b_d = s_rdata;
        s_en     = 1'b1;
        s_we     = 1'b1;
        s_addr   = SAW'(i_q);
        s_wdata  = s_rdata;
      end
      rc4_pkg::OP_GEN_WR_J: begin
        s_en    = 1'b1;
        s_we    = 1'b1;
        s_addr  = SAW'(j_q);
        s_wdata = hold_a_q;
      end
      rc4_pkg::OP_GEN_RD_T: begin
        s_en   = 1'b1;
        s_addr = SAW'(hold_a_q + hold_b_q);
      end
      rc4_pkg::OP_OUT_KEYED: begin
        out_d.cipher_byte = item_q.item_byte ^ s_rdata;
        out_d.keyed       = 1'b1;
        out_valid_d       = 1'b1;
      end
      rc4_pkg::OP_OUT_RAW: begin
        out_d.cipher_byte = item_q.item_byte;
        out_d.keyed       = 1'b0;
        out_valid_d       = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      key_count_q <= '0;
      key_open_q  <= 1'b0;
      key_ready_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      key_count_q <= key_count_d;
      key_open_q  <= key_open_d;
      key_ready_q <= key_ready_d;
      i_q         <= i_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
    end
    out_q    <= out_d;
    n_q      <= n_d;
    k_q      <= k_d;
    acc_q    <= acc_d;
    hold_a_q <= hold_a_d;
    hold_b_q <= hold_b_d;
  end

  rc4_ram #(
    .WIDTH(BW),
    .DEPTH(rc4_pkg::SBOX_DEPTH)
  ) u_sbox_ram (
    .clk_i  (clk_i),
    .en_i   (s_en),
    .we_i   (s_we),
    .addr_i (s_addr),
    .wdata_i(s_wdata),
    .rdata_o(s_rdata)
  );

  rc4_ram #(
    .WIDTH(BW),
    .DEPTH(rc4_pkg::MAX_KEY_BYTES)
  ) u_key_ram (
    .clk_i  (clk_i),
    .en_i   (k_en),
    .we_i   (k_we),
    .addr_i (k_addr),
    .wdata_i(k_wdata),
    .rdata_o(k_rdata)
  );

  assign sts_o.mode      = item_q.mode;
  assign sts_o.key_last  = item_q.key_last;
  assign sts_o.key_ready = key_ready_q;
  assign sts_o.n_wrap    = (n_q == SAW'(rc4_pkg::SBOX_DEPTH - 1));
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A key that is still being entered can never be marked ready at the same time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(key_open_q && key_ready_q))
    else $error("key open and key ready together");

  // The key length saturates at the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_count_q <= KCW'(rc4_pkg::MAX_KEY_BYTES))
    else $error("key count beyond key store depth");

  // A finished key always has at least one stored byte to repeat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_ready_q |-> (key_count_q != '0))
    else $error("key ready with empty key store");

endmodule

FILE: sv/rc4_stream_cipher.sv
// One item is in work at a time; a new item is taken only when the controller is idle.
// A final key byte is followed by the S-box fill and the key schedule before the next item is taken.
// A keyed data byte runs the keystream steps; an unkeyed one passes unchanged; both can wait on a stalled output.
// The step sequences come from the single-port S-box memory with its registered read.
// Reset clears the controller, the indices i and j, key flags, key count and output valid;
// the S-box and key store are left as they are and need no clearing pass.
module rc4_stream_cipher (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rc4_pkg::in_t  in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rc4_pkg::out_t out_item_o
);

  rc4_pkg::dp_cmd_t cmd;
  rc4_pkg::dp_sts_t sts;

  rc4_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rc4_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
